>>> rtl/kars_pkg.sv
package kars_pkg;

    // Fixed field widths of the stream items.
    localparam int SLOTS    = 8;
    localparam int ACTION_W = 3;
    localparam int CH_W     = 3;
    localparam int TIME_W   = 32;
    localparam int TMO_W    = 16;
    localparam int RETRY_W  = 4;
    localparam int EVENT_W  = 2;

    // Packed stream widths, padded to whole bytes.
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 8;

    // Parameter defaults.
    localparam int CHANNELS_DEF    = 8;
    localparam int MAX_TRIES_DEF   = 3;
    localparam int MIN_TIMEOUT_DEF = 500;

    localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd1000;

    // Action codes.
    localparam logic [ACTION_W-1:0] ACT_SCAN     = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_ACCEPT   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_START    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_STOP     = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_SEND_ALL = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_QUERY    = 3'd5;

    // Event codes of a result.
    localparam logic [EVENT_W-1:0] EV_NONE   = 2'd0;
    localparam logic [EVENT_W-1:0] EV_SEND   = 2'd1;
    localparam logic [EVENT_W-1:0] EV_ERROR  = 2'd2;
    localparam logic [EVENT_W-1:0] EV_STATUS = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // latch the accepted item
        logic step;     // process the channel under the cursor in a sweep
        logic single;   // execute a single-channel action
        logic finish;   // emit the held result as the final one
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sweep;      // incoming action visits all channels
        logic hit;        // channel under the cursor produces an event
        logic pend_valid; // a result is held back
        logic out_free;   // output register can take a transfer
        logic idx_last;   // cursor is on the last channel
    } sts_t;

endpackage

>>> rtl/kars_ctrl.sv
module kars_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  kars_pkg::sts_t sts,
    output kars_pkg::cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_SINGLE = 4'b0100,
        ST_FINAL  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);

    // Sequencing of one item: sweep or single action, then the final transfer.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = sts.sweep ? ST_SCAN : ST_SINGLE;
                end
            end
            ST_SCAN: begin
                // A new event must push the held one out, so wait for room.
                if (!(sts.hit && sts.pend_valid && !sts.out_free)) begin
                    cmd.step = 1'b1;
                    if (sts.idx_last) begin
                        state_next = ST_FINAL;
                    end
                end
            end
            ST_SINGLE: begin
                cmd.single = 1'b1;
                state_next = ST_FINAL;
            end
            ST_FINAL: begin
                if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/kars_datapath.sv
module kars_datapath #(
    parameter int CHANNELS    = kars_pkg::CHANNELS_DEF,
    parameter int MAX_TRIES   = kars_pkg::MAX_TRIES_DEF,
    parameter int MIN_TIMEOUT = kars_pkg::MIN_TIMEOUT_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [kars_pkg::CH_W-1:0]      cfg_index,
    input  logic [kars_pkg::TMO_W-1:0]     cfg_data,
    input  logic [kars_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           m_tready,
    output logic                           m_tvalid,
    output logic                           m_tlast,
    output logic [kars_pkg::M_TDATA_W-1:0] m_tdata,
    input  kars_pkg::cmd_t                 cmd,
    output kars_pkg::sts_t                 sts
);

    localparam int NCH = (CHANNELS < kars_pkg::SLOTS) ? CHANNELS : kars_pkg::SLOTS;
    localparam logic [kars_pkg::CH_W-1:0]    LAST_IDX = kars_pkg::CH_W'(NCH - 1);
    localparam logic [kars_pkg::CH_W:0]      NCH_W    = (kars_pkg::CH_W + 1)'(NCH);
    localparam logic [kars_pkg::RETRY_W-1:0] TRIES    = kars_pkg::RETRY_W'(MAX_TRIES);
    localparam logic [kars_pkg::TMO_W-1:0]   MIN_TMO  = kars_pkg::TMO_W'(MIN_TIMEOUT);

    // Channel state and timeout registers.
    logic [kars_pkg::TMO_W-1:0]   timeout_reg  [kars_pkg::SLOTS];
    logic [kars_pkg::TIME_W-1:0]  deadline_reg [kars_pkg::SLOTS];
    logic [kars_pkg::RETRY_W-1:0] retry_reg    [kars_pkg::SLOTS];
    logic [kars_pkg::SLOTS-1:0]   active_reg;
    logic [kars_pkg::SLOTS-1:0]   error_reg;

    // Latched item and channel cursor.
    logic [kars_pkg::ACTION_W-1:0] action_reg;
    logic [kars_pkg::TIME_W-1:0]   now_reg;
    logic [kars_pkg::CH_W-1:0]     idx_reg;

    // Held-back result, so that the final one can be marked last.
    logic                         pend_valid_reg;
    logic [kars_pkg::CH_W-1:0]    pend_ch_reg;
    logic [kars_pkg::EVENT_W-1:0] pend_ev_reg;
    logic                         pend_err_reg;
    logic                         pend_act_reg;

    // Output register.
    logic                           out_valid_reg;
    logic                           out_last_reg;
    logic [kars_pkg::M_TDATA_W-1:0] out_data_reg;

    logic [kars_pkg::ACTION_W-1:0] in_action;
    logic [kars_pkg::TMO_W-1:0]    tmo_raw;
    logic [kars_pkg::TMO_W-1:0]    tmo_eff;
    logic [kars_pkg::TIME_W-1:0]   rearm_dl;
    logic                          is_scan;
    logic                          chan_due;
    logic                          hit;
    logic                          tries_left;
    logic [kars_pkg::EVENT_W-1:0]  sw_ev;
    logic                          sw_err;
    logic                          op_valid;
    logic                          do_rearm;
    logic                          sg_act;
    logic                          sg_err;
    logic [kars_pkg::EVENT_W-1:0]  sg_ev;
    logic                          push_pend;

    assign in_action = s_tdata[2:0];

    // Effective timeout and new deadline for the channel under the cursor.
    assign tmo_raw  = timeout_reg[idx_reg];
    assign tmo_eff  = (tmo_raw < MIN_TMO) ? MIN_TMO : tmo_raw;
    assign rearm_dl = now_reg + {{(kars_pkg::TIME_W - kars_pkg::TMO_W){1'b0}}, tmo_eff};

    // Sweep decision for the channel under the cursor.
    assign is_scan    = (action_reg == kars_pkg::ACT_SCAN);
    assign chan_due   = active_reg[idx_reg] && !error_reg[idx_reg]
                        && (deadline_reg[idx_reg] < now_reg);
    assign hit        = is_scan ? chan_due : active_reg[idx_reg];
    assign tries_left = (retry_reg[idx_reg] < TRIES);
    always_comb begin
        if (is_scan) begin
            sw_ev  = tries_left ? kars_pkg::EV_SEND : kars_pkg::EV_ERROR;
            sw_err = !tries_left;
        end else begin
            sw_ev  = kars_pkg::EV_SEND;
            sw_err = error_reg[idx_reg];
        end
    end

    // Single-channel actions and the flags they leave behind.
    assign op_valid = ({1'b0, idx_reg} < NCH_W) && (action_reg <= kars_pkg::ACT_QUERY);
    assign do_rearm = op_valid && ((action_reg == kars_pkg::ACT_ACCEPT)
                                   || (action_reg == kars_pkg::ACT_START));
    always_comb begin
        sg_act = active_reg[idx_reg];
        if (action_reg == kars_pkg::ACT_START) begin
            sg_act = 1'b1;
        end else if (action_reg == kars_pkg::ACT_STOP) begin
            sg_act = 1'b0;
        end
        sg_err = do_rearm ? 1'b0 : error_reg[idx_reg];
        sg_ev  = (action_reg == kars_pkg::ACT_QUERY) ? kars_pkg::EV_STATUS : kars_pkg::EV_NONE;
        if (!op_valid) begin
            sg_act = 1'b0;
            sg_err = 1'b0;
            sg_ev  = kars_pkg::EV_NONE;
        end
    end

    assign push_pend = cmd.step && hit && pend_valid_reg;

    // Configuration and channel state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < kars_pkg::SLOTS; i++) begin
                timeout_reg[i]  <= kars_pkg::TIMEOUT_RESET;
                deadline_reg[i] <= '0;
                retry_reg[i]    <= '0;
            end
            active_reg <= '0;
            error_reg  <= '0;
        end else begin
            if (cfg_we) begin
                timeout_reg[cfg_index] <= cfg_data;
            end
            if (cmd.step && hit && is_scan) begin
                if (tries_left) begin
                    retry_reg[idx_reg]    <= retry_reg[idx_reg] + 1'b1;
                    deadline_reg[idx_reg] <= rearm_dl;
                end else begin
                    error_reg[idx_reg] <= 1'b1;
                end
            end
            if (cmd.single && op_valid) begin
                active_reg[idx_reg] <= sg_act;
                if (do_rearm) begin
                    deadline_reg[idx_reg] <= rearm_dl;
                    retry_reg[idx_reg]    <= '0;
                    error_reg[idx_reg]    <= 1'b0;
                end
            end
        end
    end

    // Control flags of the held result and the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cmd.finish) begin
                pend_valid_reg <= 1'b0;
            end else if ((cmd.step && hit) || cmd.single) begin
                pend_valid_reg <= 1'b1;
            end
            if (push_pend || cmd.finish) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Item, cursor and result payload.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            action_reg <= in_action;
            now_reg    <= s_tdata[37:6];
            idx_reg    <= sts.sweep ? '0 : s_tdata[5:3];
        end else if (cmd.step) begin
            idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.step && hit) begin
            pend_ch_reg  <= idx_reg;
            pend_ev_reg  <= sw_ev;
            pend_err_reg <= sw_err;
            pend_act_reg <= 1'b1;
        end else if (cmd.single) begin
            pend_ch_reg  <= idx_reg;
            pend_ev_reg  <= sg_ev;
            pend_err_reg <= sg_err;
            pend_act_reg <= sg_act;
        end
        if (push_pend) begin
            out_data_reg <= {1'b0, pend_act_reg, pend_err_reg, pend_ev_reg, pend_ch_reg};
            out_last_reg <= 1'b0;
        end else if (cmd.finish) begin
            // A run without any event still reports one empty result.
            if (pend_valid_reg) begin
                out_data_reg <= {1'b0, pend_act_reg, pend_err_reg, pend_ev_reg, pend_ch_reg};
            end else begin
                out_data_reg <= {1'b0, 1'b0, 1'b0, kars_pkg::EV_NONE, {kars_pkg::CH_W{1'b0}}};
            end
            out_last_reg <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = out_data_reg;

    assign sts.sweep      = (in_action == kars_pkg::ACT_SCAN)
                            || (in_action == kars_pkg::ACT_SEND_ALL);
    assign sts.hit        = hit;
    assign sts.pend_valid = pend_valid_reg;
    assign sts.out_free   = !out_valid_reg || m_tready;
    assign sts.idx_last   = (idx_reg == LAST_IDX);

endmodule

>>> rtl/keepalive_retry_supervisor_core.sv
// Keepalive supervisor for up to eight link channels with retry counting.
// Input stream (s_): one transfer is one command: scan, accept, start, stop,
// send-all or query, with a channel number and the current time in ms.
// Output stream (m_): one or more result transfers per command; the final
// one carries tlast. Scan and send-all give one result per channel event,
// or a single empty result when no channel has an event.
// Configuration: cfg_we writes a 16-bit channel timeout at cfg_index at once.
// Sequencing: a single-channel command passes a single and a final state,
// while scan and send-all visit the channels (CHANNELS, capped at eight),
// as one shared compare and deadline adder visits one channel per cycle
// unless the output stalls. The final state waits for a free output register.
// The output is registered, so a new command is accepted while the final
// result of the previous one still waits for m_tready. A stalled receiver
// holds a sweep on the channel that produces the next event.
// Reset (aresetn low, synchronous) clears all channel state, sets every
// timeout to 1000 ms and empties the output register.
module keepalive_retry_supervisor_core #(
    parameter int CHANNELS    = kars_pkg::CHANNELS_DEF,
    parameter int MAX_TRIES   = kars_pkg::MAX_TRIES_DEF,
    parameter int MIN_TIMEOUT = kars_pkg::MIN_TIMEOUT_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [kars_pkg::CH_W-1:0]      cfg_index,
    input  logic [kars_pkg::TMO_W-1:0]     cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // action [2:0], channel [5:3], now_ms [37:6], zero pad [39:38]
    input  logic [kars_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic                           m_tlast,
    // out_channel [2:0], event_res [4:3], error_flag [5], active_flag [6], zero pad [7]
    output logic [kars_pkg::M_TDATA_W-1:0] m_tdata
);

    kars_pkg::cmd_t cmd;
    kars_pkg::sts_t sts;

    kars_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    kars_datapath #(
        .CHANNELS    (CHANNELS),
        .MAX_TRIES   (MAX_TRIES),
        .MIN_TIMEOUT (MIN_TIMEOUT)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tlast   (m_tlast),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

>>> rtl/kars_checker.sv
module kars_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic                           m_tlast,
    input logic [kars_pkg::M_TDATA_W-1:0] m_tdata
);

    // The output register is empty right after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A result that the receiver has not taken stays offered.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // Status replies and empty results always close their command.
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[4:3] == kars_pkg::EV_STATUS) |-> m_tlast)
        else $error("status reply not marked last");

    a_none_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[4:3] == kars_pkg::EV_NONE) |-> m_tlast)
        else $error("empty result not marked last");

    // A raised link error reports an active channel with its error set.
    a_error_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[4:3] == kars_pkg::EV_ERROR) |-> m_tdata[5] && m_tdata[6])
        else $error("link error result with wrong flags");

endmodule

bind keepalive_retry_supervisor_core kars_checker u_kars_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast),
    .m_tdata  (m_tdata)
);
